[sv/delimited_block_tokenizer_macros.svh]
// Assertion macros used by the tokenizer's top-level RTL file.
`ifndef DELIMITED_BLOCK_TOKENIZER_MACROS_SVH
`define DELIMITED_BLOCK_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DBT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dbt_pkg.sv]
// Shared constants, codes and types of the delimited block tokenizer.
package dbt_pkg;

    // Lookahead window and mark sizes.
    localparam int MARK_MAX     = 4;
    localparam int MARK_W       = 8 * MARK_MAX;
    localparam int MARK_IDX_W   = $clog2(MARK_MAX);
    localparam int MARK_CNT_W   = $clog2(MARK_MAX + 1);
    localparam int MARK_LEN_LIM = (MARK_MAX < 4) ? MARK_MAX : 4;

    // Offsets and lengths saturate at the top of their range.
    localparam int               OFF_W      = 16;
    localparam logic [OFF_W-1:0] OFFSET_MAX = 16'hFFFF;

    // Configuration port.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_RAW_W  = 3;
    localparam int MAP_W      = 256;
    localparam int CHAR_W     = 8;

    // Reset delimiter set: tab, line feed, carriage return and space.
    localparam logic [CFG_DATA_W-1:0] DELIM_LO_RST = 64'h0000_0001_0000_2600;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIM_LO     = 3'd0,
        CFG_DELIM_MID_LO = 3'd1,
        CFG_DELIM_MID_HI = 3'd2,
        CFG_DELIM_HI     = 3'd3,
        CFG_OPEN_MARK    = 3'd4,
        CFG_OPEN_LEN     = 3'd5,
        CFG_CLOSE_MARK   = 3'd6,
        CFG_CLOSE_LEN    = 3'd7
    } t_cfg_idx;

    // Result status and token kind codes.
    localparam logic [1:0] STATUS_TOKEN    = 2'd0;
    localparam logic [1:0] STATUS_END      = 2'd1;
    localparam logic [1:0] STATUS_UNCLOSED = 2'd2;
    localparam logic       KIND_WORD       = 1'b0;
    localparam logic       KIND_BLOCK      = 1'b1;

    // Configuration as seen by the scanner, with mark lengths already clamped.
    typedef struct packed {
        logic [MAP_W-1:0]      delim_map;
        logic [MARK_W-1:0]     open_mark;
        logic [MARK_CNT_W-1:0] open_len;
        logic [MARK_W-1:0]     close_mark;
        logic [MARK_CNT_W-1:0] close_len;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [OFF_W-1:0] token_start;
        logic [OFF_W-1:0] token_length;
        logic             token_kind;
        logic [1:0]       status;
        logic             last;
    } t_result;

endpackage

[sv/dbt_cfg_regs.sv]
// Configuration registers of the tokenizer, with mark length clamping.
module dbt_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dbt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dbt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output dbt_pkg::t_cfg                  o_cfg
);
    import dbt_pkg::*;

    logic [CFG_DATA_W-1:0] r_delim [4];
    logic [MARK_W-1:0]     r_open_mark;
    logic [LEN_RAW_W-1:0]  r_open_len;
    logic [MARK_W-1:0]     r_close_mark;
    logic [LEN_RAW_W-1:0]  r_close_len;

    // Register writes, one index per write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim[0]   <= DELIM_LO_RST;
            r_delim[1]   <= '0;
            r_delim[2]   <= '0;
            r_delim[3]   <= '0;
            r_open_mark  <= '0;
            r_open_len   <= '0;
            r_close_mark <= '0;
            r_close_len  <= LEN_RAW_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DELIM_LO:     r_delim[0]   <= i_cfg_data;
                CFG_DELIM_MID_LO: r_delim[1]   <= i_cfg_data;
                CFG_DELIM_MID_HI: r_delim[2]   <= i_cfg_data;
                CFG_DELIM_HI:     r_delim[3]   <= i_cfg_data;
                CFG_OPEN_MARK:    r_open_mark  <= i_cfg_data[MARK_W-1:0];
                CFG_OPEN_LEN:     r_open_len   <= i_cfg_data[LEN_RAW_W-1:0];
                CFG_CLOSE_MARK:   r_close_mark <= i_cfg_data[MARK_W-1:0];
                CFG_CLOSE_LEN:    r_close_len  <= i_cfg_data[LEN_RAW_W-1:0];
                default: ;
            endcase
        end
    end

    // Lengths beyond the window clamp to it; a zero closing length means one byte.
    always_comb begin
        o_cfg.delim_map  = {r_delim[3], r_delim[2], r_delim[1], r_delim[0]};
        o_cfg.open_mark  = r_open_mark;
        o_cfg.close_mark = r_close_mark;
        if (r_open_len > LEN_RAW_W'(MARK_LEN_LIM)) begin
            o_cfg.open_len = MARK_CNT_W'(MARK_LEN_LIM);
        end else begin
            o_cfg.open_len = MARK_CNT_W'(r_open_len);
        end
        if (r_close_len == '0) begin
            o_cfg.close_len = MARK_CNT_W'(1);
        end else if (r_close_len > LEN_RAW_W'(MARK_LEN_LIM)) begin
            o_cfg.close_len = MARK_CNT_W'(MARK_LEN_LIM);
        end else begin
            o_cfg.close_len = MARK_CNT_W'(r_close_len);
        end
    end

endmodule

[sv/dbt_scan_core.sv]
// Input register, lookahead window and single-pass token scanner.
module dbt_scan_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dbt_pkg::t_cfg              i_cfg,
    input  logic                       i_in_valid,
    input  logic [dbt_pkg::CHAR_W-1:0] i_char_in,
    input  logic                       i_end_of_string,
    output logic                       o_in_stall,
    input  logic                       i_out_space,
    output logic                       o_res_push,
    output dbt_pkg::t_result           o_res,
    output logic                       o_draining
);
    import dbt_pkg::*;

    typedef enum logic [1:0] {
        MODE_SKIP  = 2'd0,
        MODE_WORD  = 2'd1,
        MODE_BLOCK = 2'd2
    } t_mode;

    typedef enum logic {
        PH_RUN   = 1'b0,
        PH_DRAIN = 1'b1
    } t_phase;

    typedef logic [MARK_MAX-1:0][CHAR_W-1:0] t_window;

    // Saturating offset advance.
    function automatic logic [OFF_W-1:0] f_sat_add(input logic [OFF_W-1:0] a,
                                                   input logic [MARK_CNT_W-1:0] n);
        logic [OFF_W:0] s;
        s = {1'b0, a} + (OFF_W + 1)'(n);
        return (s > {1'b0, OFFSET_MAX}) ? OFFSET_MAX : s[OFF_W-1:0];
    endfunction

    // True when the first len window bytes equal the mark and are all present.
    function automatic logic f_match(input t_window w, input logic [MARK_CNT_W-1:0] fill,
                                     input logic [MARK_W-1:0] mark,
                                     input logic [MARK_CNT_W-1:0] len);
        logic hit;
        hit = (len <= fill);
        for (int i = 0; i < MARK_MAX; i++) begin
            if ((MARK_CNT_W'(i) < len) && (w[i] != mark[8*i +: 8])) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic t_result f_result(input logic [OFF_W-1:0] start,
                                         input logic [OFF_W-1:0] len, input logic kind,
                                         input logic [1:0] status, input logic last);
        t_result r;
        r.token_start  = start;
        r.token_length = len;
        r.token_kind   = kind;
        r.status       = status;
        r.last         = last;
        return r;
    endfunction

    logic                  r_in_valid, n_in_valid;
    logic [CHAR_W-1:0]     r_in_char, n_in_char;
    logic                  r_in_eos, n_in_eos;
    t_window               r_win, n_win;
    logic [MARK_IDX_W-1:0] r_fill, n_fill;
    t_mode                 r_mode, n_mode;
    t_phase                r_phase, n_phase;
    logic [OFF_W-1:0]      r_start, n_start;
    logic [OFF_W-1:0]      r_head, n_head;
    logic                  r_swallow, n_swallow;

    logic                  take, run_byte, run_swallow, run_end, drain_step, front;
    t_window               pre_win, shift_win;
    logic [MARK_CNT_W-1:0] pre_fill, pop_n;
    logic [CHAR_W-1:0]     f_char;
    logic                  f_delim, f_open, f_close, f_emit, f_set_swallow;
    t_mode                 f_mode;
    logic [OFF_W-1:0]      f_start, f_end;
    t_result               f_res;

    // The item in the input register is taken when the scanner is not draining and there is room for a result.
    assign take       = (r_phase == PH_RUN) && r_in_valid && i_out_space;
    assign o_in_stall = r_in_valid && !take;
    assign o_draining = (r_phase == PH_DRAIN);

    // Kind of work done this cycle.
    assign run_byte    = take && !r_in_eos && !r_swallow;
    assign run_swallow = take && !r_in_eos && r_swallow;
    assign run_end     = take && r_in_eos;
    assign drain_step  = (r_phase == PH_DRAIN) && i_out_space;

    // Window with the new byte appended, then one front decision on it.
    always_comb begin
        pre_win  = r_win;
        pre_fill = MARK_CNT_W'(r_fill);
        if (run_byte) begin
            pre_win[r_fill] = r_in_char;
            pre_fill        = pre_fill + MARK_CNT_W'(1);
        end
        front = (run_byte && (pre_fill == MARK_CNT_W'(MARK_MAX)))
             || (drain_step && (r_fill != '0));
    end

    // Front decision: skip a delimiter, open a token, close a word or a block.
    always_comb begin
        f_char        = pre_win[0];
        f_delim       = i_cfg.delim_map[f_char];
        f_open        = (i_cfg.open_len != '0)
                     && f_match(pre_win, pre_fill, i_cfg.open_mark, i_cfg.open_len);
        f_close       = f_match(pre_win, pre_fill, i_cfg.close_mark, i_cfg.close_len);
        f_end         = f_sat_add(r_head, i_cfg.close_len);
        pop_n         = MARK_CNT_W'(1);
        f_emit        = 1'b0;
        f_mode        = r_mode;
        f_start       = r_start;
        f_set_swallow = 1'b0;
        f_res         = f_result(r_start, r_head - r_start, KIND_WORD, STATUS_TOKEN, run_byte);
        unique case (r_mode)
            MODE_SKIP: begin
                if (!f_delim) begin
                    f_start = r_head;
                    if (f_open) begin
                        f_mode = MODE_BLOCK;
                        pop_n  = i_cfg.open_len;
                    end else begin
                        f_mode = MODE_WORD;
                    end
                end
            end
            MODE_WORD: begin
                if (f_delim) begin
                    f_emit = 1'b1;
                    f_mode = MODE_SKIP;
                end
            end
            MODE_BLOCK: begin
                if (f_close) begin
                    f_emit = 1'b1;
                    f_mode = MODE_SKIP;
                    f_res  = f_result(r_start, f_end - r_start, KIND_BLOCK, STATUS_TOKEN,
                                      run_byte);
                    // The byte after the closing mark is dropped now or on arrival.
                    if (pre_fill > i_cfg.close_len) begin
                        pop_n = i_cfg.close_len + MARK_CNT_W'(1);
                    end else begin
                        pop_n         = i_cfg.close_len;
                        f_set_swallow = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Window after popping the consumed bytes from the front.
    always_comb begin
        for (int i = 0; i < MARK_MAX; i++) begin
            shift_win[i] = '0;
            for (int k = 0; k < MARK_MAX - i; k++) begin
                if (MARK_CNT_W'(k) == pop_n) begin
                    shift_win[i] = pre_win[i + k];
                end
            end
        end
    end

    // Next state and the result pushed this cycle.
    always_comb begin
        n_in_valid = r_in_valid;
        n_in_char  = r_in_char;
        n_in_eos   = r_in_eos;
        n_win      = r_win;
        n_fill     = r_fill;
        n_mode     = r_mode;
        n_phase    = r_phase;
        n_start    = r_start;
        n_head     = r_head;
        n_swallow  = r_swallow;
        o_res_push = 1'b0;
        o_res      = f_res;

        // Input register.
        if (i_in_valid && !o_in_stall) begin
            n_in_valid = 1'b1;
            n_in_char  = i_char_in;
            n_in_eos   = i_end_of_string;
        end else if (take) begin
            n_in_valid = 1'b0;
        end

        // Byte after a closed block is skipped without entering the window.
        if (run_swallow) begin
            n_swallow = 1'b0;
            n_head    = f_sat_add(r_head, MARK_CNT_W'(1));
        end else if (run_byte && !front) begin
            n_win  = pre_win;
            n_fill = MARK_IDX_W'(pre_fill);
        end

        if (front) begin
            n_win      = shift_win;
            n_fill     = MARK_IDX_W'(pre_fill - pop_n);
            n_head     = f_sat_add(r_head, pop_n);
            n_mode     = f_mode;
            n_start    = f_start;
            n_swallow  = r_swallow || f_set_swallow;
            o_res_push = f_emit;
        end

        if (run_end) begin
            n_phase = PH_DRAIN;
        end

        // Window empty at end of string: report the pending token and the status.
        if (drain_step && (r_fill == '0)) begin
            o_res_push = 1'b1;
            unique case (r_mode)
                MODE_BLOCK: begin
                    o_res = f_result(r_start, r_head - r_start, KIND_BLOCK,
                                     STATUS_UNCLOSED, 1'b1);
                end
                MODE_WORD: begin
                    o_res  = f_result(r_start, r_head - r_start, KIND_WORD,
                                      STATUS_TOKEN, 1'b0);
                    n_mode = MODE_SKIP;
                end
                default: begin
                    o_res = f_result(r_head, '0, KIND_WORD, STATUS_END, 1'b1);
                end
            endcase
            if (r_mode != MODE_WORD) begin
                n_fill    = '0;
                n_mode    = MODE_SKIP;
                n_start   = '0;
                n_head    = '0;
                n_swallow = 1'b0;
                n_phase   = PH_RUN;
            end
        end
    end

    // State and input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_fill     <= '0;
            r_mode     <= MODE_SKIP;
            r_phase    <= PH_RUN;
            r_start    <= '0;
            r_head     <= '0;
            r_swallow  <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_fill     <= n_fill;
            r_mode     <= n_mode;
            r_phase    <= n_phase;
            r_start    <= n_start;
            r_head     <= n_head;
            r_swallow  <= n_swallow;
        end
        r_in_char <= n_in_char;
        r_in_eos  <= n_in_eos;
        r_win     <= n_win;
    end

endmodule

[sv/dbt_out_buf.sv]
// Two-entry result buffer that decouples the scanner from output stalls.
module dbt_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dbt_pkg::t_result i_res,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_stall,
    output dbt_pkg::t_result o_res
);
    import dbt_pkg::*;

    t_result    r_buf [2];
    logic       r_rd_ptr, r_wr_ptr;
    logic [1:0] r_count;
    logic       pop;

    // Room is judged from registered state only.
    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_res   = r_buf[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_res;
        end
    end

endmodule

[sv/delimited_block_tokenizer.sv]
// Top level of the delimited block tokenizer.
//
// Input channel: one byte per item (i_char_in), or a string terminator when
// i_end_of_string is high. An item is taken when i_in_valid is high and
// o_in_stall is low. Output channel: token and status items, taken when
// o_out_valid is high and i_out_stall is low; o_last marks the final result
// caused by an input item. Configuration is a plain write port, used while
// the block is idle.
// An accepted item is held in the input register; its results are registered
// in the result buffer. Throughput: one byte item per cycle while the buffer
// has room, set by the single-pass window decision. A terminator drains the
// bytes still in the four-byte lookahead window (0 to 3) through the same
// decision logic, then reports an open word if any, and last the status.
// Reset is synchronous and active low: configuration returns to its defaults
// (white space as delimiters, blocks off) and the stream state to its start.
// When the receiver stalls, results wait in a two-entry buffer; once it is
// full the input register holds its item and o_in_stall rises.
`include "delimited_block_tokenizer_macros.svh"

module delimited_block_tokenizer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dbt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dbt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [dbt_pkg::CHAR_W-1:0]     i_char_in,
    input  logic                           i_end_of_string,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [dbt_pkg::OFF_W-1:0]      o_token_start,
    output logic [dbt_pkg::OFF_W-1:0]      o_token_length,
    output logic                           o_token_kind,
    output logic [1:0]                     o_status,
    output logic                           o_last
);
    import dbt_pkg::*;

    t_cfg    cfg;
    t_result core_res, out_res;
    logic    core_push, out_space, draining;

    dbt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dbt_scan_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .i_char_in       (i_char_in),
        .i_end_of_string (i_end_of_string),
        .o_in_stall      (o_in_stall),
        .i_out_space     (out_space),
        .o_res_push      (core_push),
        .o_res           (core_res),
        .o_draining      (draining)
    );

    dbt_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_push),
        .i_res   (core_res),
        .o_space (out_space),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    // Result fields.
    assign o_token_start  = out_res.token_start;
    assign o_token_length = out_res.token_length;
    assign o_token_kind   = out_res.token_kind;
    assign o_status       = out_res.status;
    assign o_last         = out_res.last;

    // The scanner never pushes into a full result buffer.
    `DBT_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, core_push, out_space, "result pushed into full buffer")

    // A final result always leaves the scanner ready for the next string.
    `DBT_ASSERT_NEXT(a_last_ends_drain, i_clk, i_rst_n, core_push && core_res.last, !draining, "scanner still draining after last result")

    // An end status carries an empty word and closes the item's results.
    `DBT_ASSERT_NOW(a_end_status_form, i_clk, i_rst_n, o_out_valid && (o_status == STATUS_END), (o_token_length == '0) && (o_token_kind == KIND_WORD) && o_last, "malformed end status result")

endmodule

[tb/tb.sv]
// Self-checking testbench for the delimited block tokenizer, with its own token predictor.
`timescale 1ns / 1ps

module tb;
    import dbt_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int STEP_RESULTS_MAX = 5;

    typedef enum logic [1:0] {
        SCAN_SKIP,
        SCAN_WORD,
        SCAN_BLOCK
    } t_scan_mode;

    // Block ports; every input is known from time zero.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [CHAR_W-1:0]     i_char_in = '0;
    logic                  i_end_of_string = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [OFF_W-1:0]      o_token_start;
    logic [OFF_W-1:0]      o_token_length;
    logic                  o_token_kind;
    logic [1:0]            o_status;
    logic                  o_last;

    // Shadow copy of the configuration registers, at their reset values.
    logic [MAP_W-1:0] delim_set = {192'b0, DELIM_LO_RST};
    logic [31:0]      open_bytes = '0;
    logic [2:0]       open_len_raw = 3'd0;
    logic [31:0]      close_bytes = '0;
    logic [2:0]       close_len_raw = 3'd1;

    // Predicted scanner state.
    logic [7:0] win [MARK_MAX];
    int         win_fill;
    t_scan_mode mode;
    int         tok_start;
    int         head_pos;
    bit         swallow;
    t_result    step_buf [STEP_RESULTS_MAX];
    int         step_count;

    t_result expected_tokens [$];

    bit quiet = 1'b0;
    bit driving = 1'b0;
    int items_sent = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    delimited_block_tokenizer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_in       (i_char_in),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_token_start   (o_token_start),
        .o_token_length  (o_token_length),
        .o_token_kind    (o_token_kind),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    // Clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run-time guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("delimited_block_tokenizer test failed");
            $finish;
        end
    end

    // The receiver stalls with a probability of about 37 percent, except in quiet stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 37);
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic int sat_pos(int a, int b);
        return (a + b > int'(OFFSET_MAX)) ? int'(OFFSET_MAX) : a + b;
    endfunction

    // Mark lengths beyond the window or four bytes are clamped.
    function automatic int mark_len(logic [2:0] raw);
        return (raw > MARK_LEN_LIM) ? MARK_LEN_LIM : int'(raw);
    endfunction

    function automatic bit window_has(logic [31:0] mark, int len);
        int i;
        if (len > win_fill) return 1'b0;
        for (i = 0; i < len; i++) begin
            if (win[i] != mark[8*i +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function void drop_front(int n);
        int i;
        if (n > win_fill) n = win_fill;
        for (i = 0; i + n < win_fill; i++) win[i] = win[i + n];
        win_fill = win_fill - n;
        head_pos = sat_pos(head_pos, n);
    endfunction

    function void push_token(int s, int e, logic kind, logic [1:0] st);
        t_result r;
        if (step_count >= STEP_RESULTS_MAX) return;
        r.token_start = OFF_W'(s);
        r.token_length = (e >= s) ? OFF_W'(e - s) : '0;
        r.token_kind = kind;
        r.status = st;
        r.last = 1'b0;
        step_buf[step_count] = r;
        step_count++;
    endfunction

    function void clear_scan();
        int i;
        for (i = 0; i < MARK_MAX; i++) win[i] = '0;
        win_fill = 0;
        mode = SCAN_SKIP;
        tok_start = 0;
        head_pos = 0;
        swallow = 1'b0;
    endfunction

    // One decision on the byte at the front of the lookahead window.
    function void decide_front();
        logic [7:0] c;
        int ol;
        int cl;
        c = win[0];
        ol = mark_len(open_len_raw);
        cl = mark_len(close_len_raw);
        if (cl == 0) cl = 1;
        case (mode)
            SCAN_SKIP: begin
                if (delim_set[c]) begin
                    drop_front(1);
                end else begin
                    tok_start = head_pos;
                    if (ol > 0 && window_has(open_bytes, ol)) begin
                        mode = SCAN_BLOCK;
                        drop_front(ol);
                    end else begin
                        mode = SCAN_WORD;
                        drop_front(1);
                    end
                end
            end
            SCAN_WORD: begin
                if (delim_set[c]) begin
                    push_token(tok_start, head_pos, KIND_WORD, STATUS_TOKEN);
                    mode = SCAN_SKIP;
                end
                drop_front(1);
            end
            default: begin
                if (window_has(close_bytes, cl)) begin
                    push_token(tok_start, sat_pos(head_pos, cl), KIND_BLOCK, STATUS_TOKEN);
                    drop_front(cl);
                    mode = SCAN_SKIP;
                    // The byte after a closing mark is dropped, now or when it arrives.
                    if (win_fill > 0) begin
                        drop_front(1);
                    end else begin
                        swallow = 1'b1;
                    end
                end else begin
                    drop_front(1);
                end
            end
        endcase
    endfunction

    // Works out the results that one accepted item causes and queues them.
    function void predict_item(logic [7:0] c, logic eos);
        t_result r;
        int i;
        step_count = 0;
        if (!eos) begin
            if (swallow) begin
                swallow = 1'b0;
                head_pos = sat_pos(head_pos, 1);
            end else begin
                if (win_fill < MARK_MAX) begin
                    win[win_fill] = c;
                    win_fill++;
                end
                if (win_fill >= MARK_MAX) decide_front();
            end
        end else begin
            while (win_fill > 0) decide_front();
            if (mode == SCAN_BLOCK) begin
                push_token(tok_start, head_pos, KIND_BLOCK, STATUS_UNCLOSED);
            end else begin
                if (mode == SCAN_WORD) push_token(tok_start, head_pos, KIND_WORD, STATUS_TOKEN);
                push_token(head_pos, head_pos, KIND_WORD, STATUS_END);
            end
            clear_scan();
        end
        for (i = 0; i < step_count; i++) begin
            r = step_buf[i];
            r.last = (i == step_count - 1);
            expected_tokens.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------- checking

    function void report_mismatch(string why, t_result want, t_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s", $time, why);
            $display("  expected start %0d length %0d kind %0d status %0d last %0d",
                     want.token_start, want.token_length, want.token_kind,
                     want.status, want.last);
            $display("  actual   start %0d length %0d kind %0d status %0d last %0d",
                     got.token_start, got.token_length, got.token_kind,
                     got.status, got.last);
        end
    endfunction

    // Each accepted result is compared with the oldest expected one.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.token_start = o_token_start;
            got.token_length = o_token_length;
            got.token_kind = o_token_kind;
            got.status = o_status;
            got.last = o_last;
            if (expected_tokens.size() == 0) begin
                report_mismatch("result arrived with none expected", '0, got);
            end else begin
                want = expected_tokens.pop_front();
                if (got.token_start !== want.token_start ||
                    got.token_length !== want.token_length ||
                    got.token_kind !== want.token_kind ||
                    got.status !== want.status ||
                    got.last !== want.last) begin
                    report_mismatch("result differs from prediction", want, got);
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Sends one item, idling at random first, and predicts on acceptance.
    task automatic send_item(logic [7:0] c, logic eos);
        while (!quiet && $urandom_range(99) < 37) begin
            if (driving) begin
                i_in_valid <= 1'b0;
                driving = 1'b0;
            end
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in <= c;
        i_end_of_string <= eos;
        driving = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_item(c, eos);
        items_sent++;
    endtask

    task automatic stop_sending();
        if (driving) begin
            i_in_valid <= 1'b0;
            driving = 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Holds the sender back until every predicted result has been seen.
    task automatic drain_results();
        stop_sending();
        while (expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_DELIM_LO:     delim_set[63:0] = data;
            CFG_DELIM_MID_LO: delim_set[127:64] = data;
            CFG_DELIM_MID_HI: delim_set[191:128] = data;
            CFG_DELIM_HI:     delim_set[255:192] = data;
            CFG_OPEN_MARK:    open_bytes = data[31:0];
            CFG_OPEN_LEN:     open_len_raw = data[2:0];
            CFG_CLOSE_MARK:   close_bytes = data[31:0];
            default:          close_len_raw = data[2:0];
        endcase
    endtask

    // Writes every register once the block has gone quiet, including a
    // terminator still draining or a byte held in the input register.
    task automatic set_config(logic [63:0] lo, logic [63:0] mlo, logic [63:0] mhi,
                              logic [63:0] hi, logic [31:0] om, logic [2:0] ol,
                              logic [31:0] cm, logic [2:0] cl);
        drain_results();
        repeat (10) @(posedge i_clk);
        write_reg(CFG_DELIM_LO, lo);
        write_reg(CFG_DELIM_MID_LO, mlo);
        write_reg(CFG_DELIM_MID_HI, mhi);
        write_reg(CFG_DELIM_HI, hi);
        write_reg(CFG_OPEN_MARK, {32'b0, om});
        write_reg(CFG_OPEN_LEN, {61'b0, ol});
        write_reg(CFG_CLOSE_MARK, {32'b0, cm});
        write_reg(CFG_CLOSE_LEN, {61'b0, cl});
        i_cfg_we <= 1'b0;
    endtask

    // Tries for a byte that is, or is not, in the delimiter set.
    function automatic logic [7:0] pick_byte(bit want_delim);
        logic [7:0] b;
        int tries;
        b = 8'($urandom);
        for (tries = 0; tries < 16 && delim_set[b] != want_delim; tries++) b = 8'($urandom);
        return b;
    endfunction

    task automatic send_text(string s, bit terminate);
        int i;
        for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
        if (terminate) send_item(8'($urandom), 1'b1);
    endtask

    // A string built from delimiter runs, words, blocks, cut marks and noise.
    task automatic send_string(int n_tokens, bit terminate);
        int t;
        int k;
        int n;
        int ol;
        int cl;
        ol = mark_len(open_len_raw);
        cl = mark_len(close_len_raw);
        if (cl == 0) cl = 1;
        for (t = 0; t < n_tokens; t++) begin
            case ($urandom_range(9))
                0, 1: repeat ($urandom_range(1, 3)) send_item(pick_byte(1'b1), 1'b0);
                2, 3: repeat ($urandom_range(1, 6)) send_item(pick_byte(1'b0), 1'b0);
                4, 5, 6: begin
                    for (k = 0; k < ol; k++) send_item(open_bytes[8*k +: 8], 1'b0);
                    repeat ($urandom_range(0, 5)) send_item(8'($urandom), 1'b0);
                    if ($urandom_range(99) < 85) begin
                        for (k = 0; k < cl; k++) send_item(close_bytes[8*k +: 8], 1'b0);
                        send_item(8'($urandom), 1'b0);
                    end
                end
                7: begin
                    n = $urandom_range(0, 3);
                    for (k = 0; k < n; k++) send_item(open_bytes[8*k +: 8], 1'b0);
                    send_item(8'($urandom), 1'b0);
                end
                default: send_item(8'($urandom), 1'b0);
            endcase
        end
        if (terminate) send_item(8'($urandom), 1'b1);
    endtask

    // ---------------------------------------------------------------- tests

    // Default white space delimiters, extreme byte values and an empty string.
    task automatic test_whitespace_words();
        send_item(8'h00, 1'b0);
        send_item(8'h20, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h09, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);
    endtask

    // Closed block with its trailing byte dropped, an unclosed block, an opening
    // mark cut by the end, and a block closed right at the end.
    task automatic test_block_marks();
        set_config(64'h0000_1001_0000_0000, '0, '0, '0, 32'h7B7B, 3'd2, 32'h7D7D, 3'd2);
        send_text("{{a}}b,c", 1'b1);
        send_text("{{ab", 1'b1);
        send_text("{", 1'b1);
        send_text("{{}}", 1'b1);
    endtask

    // Phases of random strings under changing settings, extremes first.
    task automatic test_random_phases();
        int phase;
        int first;
        int quota;
        logic [255:0] map;
        logic [31:0] om;
        logic [31:0] cm;
        logic [2:0] ol;
        logic [2:0] cl;
        first = items_sent;
        phase = 0;
        while (items_sent - first < 320) begin
            case (phase)
                0: set_config('1, '1, '1, '1, '1, 3'd7, '0, 3'd0);
                1: set_config('0, '0, '0, '0, '0, 3'd0, '1, 3'd4);
                default: begin
                    map = '0;
                    repeat ($urandom_range(1, 8)) map[$urandom_range(255)] = 1'b1;
                    if ($urandom_range(3) == 0) map[64*$urandom_range(3) +: 64] |= {$urandom, $urandom};
                    om = $urandom;
                    ol = ($urandom_range(99) < 20) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
                    cm = ($urandom_range(1) == 1) ? om : 32'($urandom);
                    cl = ($urandom_range(99) < 20) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
                    set_config(map[63:0], map[127:64], map[191:128], map[255:192], om, ol, cm, cl);
                end
            endcase
            // One phase runs with neither side idling.
            quiet = (phase == 4);
            quota = items_sent + 40;
            while (items_sent < quota) begin
                send_string($urandom_range(1, 6), 1'b1);
                if ($urandom_range(99) < 15) drain_results();
            end
            // Sometimes the string stays open across the next register writes.
            if ($urandom_range(99) < 40) send_string($urandom_range(1, 3), 1'b0);
            quiet = 1'b0;
            phase++;
        end
    endtask

    initial begin
        clear_scan();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_whitespace_words();
        test_block_marks();
        test_random_phases();
        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_tokens.size() == 0) begin
            $display("delimited_block_tokenizer test passed");
        end else begin
            $display("delimited_block_tokenizer test failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/dbt_pkg.sv
sv/dbt_cfg_regs.sv
sv/dbt_scan_core.sv
sv/dbt_out_buf.sv
sv/delimited_block_tokenizer.sv
tb/tb.sv
